// File: rtl/core/ltwe_pkg.sv
// Package: constants, types and tables of the LED twinkle effect engine.
package ltwe_pkg;

    localparam int unsigned LedTotalDefault    = 32;
    localparam int unsigned PaletteSizeDefault = 9;
    localparam logic [15:0] SeedDefault        = 16'd44257;
    localparam logic [15:0] LfsrTaps           = 16'hB400;
    localparam logic [7:0]  DefaultMax         = 8'd30;
    localparam logic [7:0]  ModeLimit          = 8'd4;
    localparam logic [7:0]  SpeedLimit         = 8'd8;

    localparam logic [7:0] CMD_RESET = 8'd0;
    localparam logic [7:0] CMD_MODE  = 8'd1;
    localparam logic [7:0] CMD_SPEED = 8'd2;
    localparam logic [7:0] CMD_COLOR = 8'd3;
    localparam logic [7:0] CMD_MAX   = 8'd4;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_TWINK = 3'd1;
    localparam logic [2:0] MODE_CYCLE = 3'd2;
    localparam logic [2:0] MODE_FILL  = 3'd3;
    localparam logic [2:0] MODE_BLANK = 3'd4;

    typedef logic [23:0] t_pixel;   // {lightness, saturation, hue}

    function automatic logic [10:0] rate_of(input logic [3:0] level);
        logic [10:0] r;
        begin
            case (level)
                4'd0:    r = 11'd10;
                4'd1:    r = 11'd15;
                4'd2:    r = 11'd30;
                4'd3:    r = 11'd50;
                4'd4:    r = 11'd100;
                4'd5:    r = 11'd200;
                4'd6:    r = 11'd500;
                4'd7:    r = 11'd1000;
                default: r = 11'd2000;
            endcase
            return r;
        end
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        return v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
    endfunction

endpackage

// File: rtl/core/ltwe_ram.sv
// Generic single-port-write, registered-read RAM.
module ltwe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/ltwe_lfsr_mod.sv
// Sequential LFSR remainder unit: v mod m, one quotient bit per cycle.
module ltwe_lfsr_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_modulus,
    output logic        o_done,
    output logic [7:0]  o_rem
);
    import ltwe_pkg::*;

    logic [15:0] r_num;
    logic [8:0]  r_rem;
    logic [7:0]  r_mod;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [8:0]  w_sh;

    assign w_sh   = {r_rem[7:0], r_num[15]};
    assign o_rem  = r_rem[7:0];
    assign o_done = r_busy && (r_cnt == 5'd16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_value;
            r_mod  <= i_modulus;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 5'd16) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 5'd1;
                r_num <= r_num << 1;
                if (r_mod == 8'd0) begin
                    r_rem <= '0;
                end else if (w_sh >= {1'b0, r_mod}) begin
                    r_rem <= w_sh - {1'b0, r_mod};
                end else begin
                    r_rem <= w_sh;
                end
            end
        end
    end
endmodule

// File: rtl/core/led_twinkle_effect_engine.sv
// Top level of the LED twinkle effect engine.
// A frame tick reads each LED's state from RAM, updates it and emits one pixel
// item per LED, going through the read, calc and output states for each LED;
// the output state holds while the output is not taken. A command is handled in
// the idle state, but a reseed runs a 16-step remainder unit per LED.
// No clearing pass: per-LED valid bits make unwritten entries read as zero.
module led_twinkle_effect_engine #(
    parameter int unsigned LED_TOTAL    = ltwe_pkg::LedTotalDefault,
    parameter int unsigned PALETTE_SIZE = ltwe_pkg::PaletteSizeDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command_code, first_argument, second_argument
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // led_index, hue_out, saturation_out,
                                        // lightness_out, frame_rate, zero fill
    output logic        m_axis_tlast    // last
);
    import ltwe_pkg::*;

    localparam int unsigned AW = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
    localparam int unsigned PW = $clog2(PALETTE_SIZE);
    localparam logic [6:0]  RepaintLimit = 7'(2 * LED_TOTAL);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CALC  = 6'b000100,
        S_OUT   = 6'b001000,
        S_SEED  = 6'b010000,
        S_SWAIT = 6'b100000
    } t_state;

    t_state r_state;
    logic [15:0] r_lfsr;
    logic [7:0]  r_pal_h [PALETTE_SIZE];
    logic [7:0]  r_pal_s [PALETTE_SIZE];
    logic [PW-1:0] r_ptr;
    logic [2:0]  r_mode;
    logic [7:0]  r_max;
    logic [3:0]  r_speed;
    logic [6:0]  r_rep;
    logic [AW-1:0] r_idx;
    logic [LED_TOTAL-1:0] r_valid;
    logic [2:0]  r_fmode;
    logic [PW-1:0] r_fptr;
    logic [AW:0] r_sidx;

    logic        w_we;
    logic [AW-1:0] w_waddr;
    t_pixel      w_wpix, w_rpix, w_pix;
    logic        w_wrise, w_rrise, w_rise;
    logic        w_mstart, w_mdone;
    logic [7:0]  w_mrem;
    logic [15:0] w_lnext;
    logic        r_sstart;

    logic [7:0]  w_ch, w_cs, w_cl;
    logic        w_cr;
    logic [23:0] w_tdata;
    t_pixel      r_opix;

    ltwe_ram #(.WIDTH(24), .DEPTH(LED_TOTAL)) u_pix (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wpix),
        .i_raddr(r_idx), .o_rdata(w_rpix));
    ltwe_ram #(.WIDTH(1), .DEPTH(LED_TOTAL)) u_dir (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wrise),
        .i_raddr(r_idx), .o_rdata(w_rrise));
    ltwe_lfsr_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_value(r_lfsr),
        .i_modulus(r_max), .o_done(w_mdone), .o_rem(w_mrem));

    assign w_tdata = s_axis_tdata;
    assign w_lnext = lfsr_step(r_lfsr);
    assign w_mstart = r_sstart;
    assign w_pix  = r_valid[r_idx] ? w_rpix : '0;
    assign w_rise = r_valid[r_idx] ? w_rrise : 1'b0;

    always_comb begin
        w_ch = w_pix[7:0];
        w_cs = w_pix[15:8];
        w_cl = w_pix[23:16];
        w_cr = w_rise;
        if (r_fmode == MODE_FILL) begin
            w_ch = r_pal_h[r_fptr];
            w_cs = r_pal_s[r_fptr];
            w_cl = r_max;
        end else if (r_fmode == MODE_BLANK) begin
            w_ch = '0;
            w_cs = '0;
            w_cl = '0;
        end else if (!w_rise) begin
            if (w_pix[23:16] == 8'd0) begin
                w_ch = r_pal_h[r_fptr];
                w_cs = r_pal_s[r_fptr];
                w_cl = 8'd1;
                w_cr = 1'b1;
            end else begin
                w_cl = w_pix[23:16] - 8'd1;
            end
        end else if (w_pix[23:16] >= r_max) begin
            w_cl = w_pix[23:16] - 8'd1;
            w_cr = 1'b0;
        end else begin
            w_cl = w_pix[23:16] + 8'd1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wpix  = {w_cl, w_cs, w_ch};
        w_wrise = w_cr;
        if (r_state == S_CALC) begin
            w_we = 1'b1;
        end else if (r_state == S_SWAIT && w_mdone) begin
            w_we    = 1'b1;
            w_waddr = r_sidx[AW-1:0];
            w_wpix  = {w_mrem, w_pix[15:0]};
            w_wrise = w_rise;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, rate_of(r_speed), r_opix[23:16], r_opix[15:8],
                            r_opix[7:0], 6'(r_idx)};
    assign m_axis_tlast  = (r_idx == AW'(LED_TOTAL - 1));

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(PALETTE_SIZE - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lfsr   <= SeedDefault;
            r_ptr    <= PW'(PALETTE_SIZE - 1);
            r_mode   <= MODE_CYCLE;
            r_max    <= DefaultMax;
            r_speed  <= '0;
            r_rep    <= '0;
            r_idx    <= '0;
            r_valid  <= '0;
            r_sstart <= 1'b0;
            r_sidx   <= '0;
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                r_pal_h[i] <= (i == PALETTE_SIZE - 1) ? 8'd0 : 8'(32 * i);
                r_pal_s[i] <= (i == PALETTE_SIZE - 1) ? 8'd0 : 8'd255;
            end
        end else begin
            r_sstart <= 1'b0;
            if (i_cfg_we) begin
                r_lfsr <= i_cfg_wdata;
            end
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (!s_axis_tuser) begin
                            r_fmode <= r_mode;
                            r_fptr  <= r_ptr;
                            r_idx   <= '0;
                            if (r_mode == MODE_BLANK) begin
                                r_mode <= MODE_IDLE;
                            end
                            if (r_mode >= MODE_TWINK && r_mode <= MODE_BLANK) begin
                                r_state <= S_READ;
                            end
                        end else begin
                            case (w_tdata[7:0])
                                CMD_RESET: begin
                                    for (int i = 0; i < PALETTE_SIZE; i++) begin
                                        r_pal_h[i] <= (i == PALETTE_SIZE - 1) ?
                                                      8'd0 : 8'(32 * i);
                                        r_pal_s[i] <= (i == PALETTE_SIZE - 1) ?
                                                      8'd0 : 8'd255;
                                    end
                                    r_ptr   <= PW'(PALETTE_SIZE - 1);
                                    r_mode  <= MODE_CYCLE;
                                    r_max   <= DefaultMax;
                                    r_speed <= '0;
                                    r_state <= S_SEED;
                                    r_sidx  <= '0;
                                end
                                CMD_MODE: begin
                                    if (w_tdata[15:8] <= ModeLimit) begin
                                        r_mode <= w_tdata[10:8];
                                        if (w_tdata[10:8] == MODE_TWINK ||
                                            w_tdata[10:8] == MODE_CYCLE) begin
                                            r_state <= S_SEED;
                                        end
                                    end else if (r_mode == MODE_TWINK ||
                                                 r_mode == MODE_CYCLE) begin
                                        r_state <= S_SEED;
                                    end
                                    r_sidx <= '0;
                                end
                                CMD_SPEED: begin
                                    if (w_tdata[15:8] <= SpeedLimit) begin
                                        r_speed <= w_tdata[11:8];
                                    end
                                end
                                CMD_COLOR: begin
                                    r_ptr <= ptr_inc(r_ptr);
                                    r_pal_h[ptr_inc(r_ptr)] <= w_tdata[15:8];
                                    r_pal_s[ptr_inc(r_ptr)] <= w_tdata[23:16];
                                end
                                CMD_MAX: begin
                                    r_max  <= w_tdata[15:8];
                                    r_sidx <= '0;
                                    if (r_mode == MODE_TWINK || r_mode == MODE_CYCLE) begin
                                        r_state <= S_SEED;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_READ: r_state <= S_CALC;
                S_CALC: begin
                    r_opix  <= {w_cl, w_cs, w_ch};
                    r_state <= S_OUT;
                    if ((r_fmode == MODE_TWINK || r_fmode == MODE_CYCLE) && !w_rise &&
                        w_pix[23:16] == 8'd0) begin
                        r_rep <= r_rep + 7'd1;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_idx == AW'(LED_TOTAL - 1)) begin
                            r_state <= S_IDLE;
                            if ((r_fmode == MODE_TWINK || r_fmode == MODE_CYCLE) &&
                                r_rep >= RepaintLimit) begin
                                r_rep <= '0;
                                if (r_fmode == MODE_CYCLE) begin
                                    r_ptr <= ptr_inc(r_ptr);
                                end
                            end
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_SEED: begin
                    r_idx    <= r_sidx[AW-1:0];
                    r_lfsr   <= w_lnext;
                    r_sstart <= 1'b1;
                    r_state  <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (w_mdone) begin
                        if (r_sidx == (AW+1)'(LED_TOTAL - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sidx  <= r_sidx + (AW+1)'(1);
                            r_state <= S_SEED;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !m_axis_tready) |=> (r_state == S_OUT && $stable(r_opix)))
        else $error("pixel changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CALC || r_state == S_SWAIT))
        else $error("pixel RAM written outside update");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken during frame output");
endmodule

// File: tb/led_twinkle_effect_engine_test.sv
// Testbench of the LED twinkle effect engine: directed table, random items, pixel predictor.
`timescale 1ns / 100ps

module led_twinkle_effect_engine_test;
    import ltwe_pkg::*;

    localparam int LEDS = 32;
    localparam int PAL = 9;
    localparam int SETTLE = 800;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]  led;
        logic [7:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  lit;
        logic [10:0] rate;
        logic        last;
    } t_pix;

    typedef struct {
        logic       op;
        logic [7:0] code;
        logic [7:0] a1;
        logic [7:0] a2;
        bit         known;
        logic [7:0] k_hue;
        logic [7:0] k_sat;
        logic [7:0] k_lit;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // command_code, first_argument, second_argument
    logic        s_axis_tuser = 1'b0; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // led_index, hue_out, saturation_out,
                                      // lightness_out, frame_rate, zero fill
    logic        m_axis_tlast;

    led_twinkle_effect_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predicted engine state
    logic [7:0]  px_hue [LEDS];
    logic [7:0]  px_sat [LEDS];
    logic [7:0]  px_lit [LEDS];
    bit          px_up [LEDS];
    logic [7:0]  pal_hue [PAL];
    logic [7:0]  pal_sat [PAL];
    logic [3:0]  pal_ptr;
    logic [2:0]  fx_mode;
    logic [7:0]  lit_max;
    logic [3:0]  speed;
    logic [6:0]  repaints;
    logic [15:0] noise;
    int          speed_rate [9] = '{10, 15, 30, 50, 100, 200, 500, 1000, 2000};

    t_pix pixels_due [$];
    int   errors = 0;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;

    function automatic logic [7:0] draw(input logic [7:0] m);
        noise = noise[0] ? ((noise >> 1) ^ LfsrTaps) : (noise >> 1);
        return (m == 0) ? 8'd0 : 8'(noise % m);
    endfunction

    function automatic void reseed_lightness();
        for (int i = 0; i < LEDS; i++) px_lit[i] = draw(lit_max);
    endfunction

    function automatic void restore_palette();
        for (int i = 0; i < PAL; i++) begin
            pal_hue[i] = 8'(32 * i);
            pal_sat[i] = 8'd255;
        end
        pal_hue[PAL-1] = 8'd0;
        pal_sat[PAL-1] = 8'd0;
        pal_ptr = 4'(PAL - 1);
        fx_mode = MODE_CYCLE;
        lit_max = DefaultMax;
        speed = 4'd0;
    endfunction

    function automatic void advance_pointer();
        pal_ptr = (pal_ptr + 1 >= PAL) ? 4'd0 : pal_ptr + 4'd1;
    endfunction

    function automatic void engine_reset(input logic [15:0] seed);
        for (int i = 0; i < LEDS; i++) begin
            px_hue[i] = '0; px_sat[i] = '0; px_lit[i] = '0; px_up[i] = 1'b0;
        end
        restore_palette();
        repaints = '0;
        noise = seed;
    endfunction

    function automatic void predict_pixels(input logic op, input logic [7:0] code,
                                           input logic [7:0] a1, input logic [7:0] a2);
        int   e;
        t_pix p;
        if (op) begin
            case (code)
                CMD_RESET: begin
                    restore_palette();
                    reseed_lightness();
                end
                CMD_MODE: begin
                    if (a1 <= ModeLimit) fx_mode = a1[2:0];
                    if (fx_mode == MODE_TWINK || fx_mode == MODE_CYCLE) reseed_lightness();
                end
                CMD_SPEED: if (a1 <= SpeedLimit) speed = a1[3:0];
                CMD_COLOR: begin
                    advance_pointer();
                    pal_hue[pal_ptr] = a1;
                    pal_sat[pal_ptr] = a2;
                end
                CMD_MAX: begin
                    lit_max = a1;
                    if (fx_mode == MODE_TWINK || fx_mode == MODE_CYCLE) reseed_lightness();
                end
                default: ;
            endcase
            return;
        end
        e = (pal_ptr < PAL) ? pal_ptr : 0;
        if (fx_mode == MODE_TWINK || fx_mode == MODE_CYCLE) begin
            for (int i = 0; i < LEDS; i++) begin
                if (!px_up[i]) begin
                    if (px_lit[i] == 0) begin
                        px_hue[i] = pal_hue[e];
                        px_sat[i] = pal_sat[e];
                        repaints = repaints + 7'd1;
                        px_lit[i] = 8'd1;
                        px_up[i] = 1'b1;
                    end else begin
                        px_lit[i] = px_lit[i] - 8'd1;
                    end
                end else if (px_lit[i] >= lit_max) begin
                    px_lit[i] = px_lit[i] - 8'd1;
                    px_up[i] = 1'b0;
                end else begin
                    px_lit[i] = px_lit[i] + 8'd1;
                end
            end
            if (repaints >= 2 * LEDS) begin
                if (fx_mode == MODE_CYCLE) advance_pointer();
                repaints = '0;
            end
        end else if (fx_mode == MODE_FILL) begin
            for (int i = 0; i < LEDS; i++) begin
                px_hue[i] = pal_hue[e];
                px_sat[i] = pal_sat[e];
                px_lit[i] = lit_max;
            end
        end else if (fx_mode == MODE_BLANK) begin
            for (int i = 0; i < LEDS; i++) begin
                px_hue[i] = '0; px_sat[i] = '0; px_lit[i] = '0;
            end
            fx_mode = MODE_IDLE;
        end else begin
            return;
        end
        for (int i = 0; i < LEDS; i++) begin
            p.led = 6'(i);
            p.hue = px_hue[i];
            p.sat = px_sat[i];
            p.lit = px_lit[i];
            p.rate = 11'(speed_rate[(speed <= 8) ? speed : 8]);
            p.last = (i == LEDS - 1);
            pixels_due.push_back(p);
        end
    endfunction

    task automatic send_item(input logic op, input logic [7:0] code,
                             input logic [7:0] a1, input logic [7:0] a2);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {a2, a1, code};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixels(op, code, a1, a2);
    endtask

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [15:0] seed);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        noise = seed;
    endtask

    task automatic random_item();
        logic [7:0] code, a1, a2;
        a2 = 8'($urandom);
        a1 = 8'($urandom);
        if ($urandom_range(0, 99) < 62) begin
            send_item(1'b0, 8'($urandom), a1, a2);
            idle_burst();
            return;
        end
        case ($urandom_range(0, 9))
            0:       code = CMD_RESET;
            1, 2:    code = CMD_MODE;
            3:       code = CMD_SPEED;
            4, 5:    code = CMD_COLOR;
            6, 7:    code = CMD_MAX;
            default: code = 8'($urandom);
        endcase
        if ($urandom_range(0, 4) != 0) begin
            if (code == CMD_MODE) a1 = 8'($urandom_range(0, 5));
            if (code == CMD_SPEED) a1 = 8'($urandom_range(0, 10));
            if (code == CMD_MAX) a1 = 8'($urandom_range(0, 40));
        end
        send_item(1'b1, code, a1, a2);
        idle_burst();
    endtask

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel expected none actual %h", $time, m_axis_tdata);
            end else begin
                want = pixels_due.pop_front();
                check_field("led_index", 11'(want.led), 11'(m_axis_tdata[5:0]));
                check_field("hue", 11'(want.hue), 11'(m_axis_tdata[13:6]));
                check_field("saturation", 11'(want.sat), 11'(m_axis_tdata[21:14]));
                check_field("lightness", 11'(want.lit), 11'(m_axis_tdata[29:22]));
                check_field("frame_rate", want.rate, m_axis_tdata[40:30]);
                check_field("fill", 11'd0, 11'(m_axis_tdata[47:41]));
                check_field("last", 11'(want.last), 11'(m_axis_tlast));
            end
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    int quiet = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    t_row table_rows [] = '{
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd1},
        '{1'b1, CMD_MODE,  8'd4,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'hff,     8'hff,  8'hff,  1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_COLOR, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_MAX,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_MODE,  8'd3,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b1, 8'd255, 8'd255, 8'd255},
        '{1'b1, CMD_MAX,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b1, 8'd255, 8'd255, 8'd0},
        '{1'b1, CMD_SPEED, 8'd8,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_SPEED, 8'd9,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_MODE,  8'd5,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd255,    8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_MODE,  8'd1,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_MAX,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_MODE,  8'd2,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_RESET, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_COLOR, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, CMD_SPEED, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic [15:0] seeds [4];

    initial begin
        seeds = '{16'd1, 16'd65535, 16'($urandom_range(1, 65535)), SeedDefault};
        engine_reset(SeedDefault);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[r]) begin
            send_item(table_rows[r].op, table_rows[r].code, table_rows[r].a1, table_rows[r].a2);
            if (table_rows[r].known) begin
                pixels_due[pixels_due.size() - LEDS].hue = table_rows[r].k_hue;
                pixels_due[pixels_due.size() - LEDS].sat = table_rows[r].k_sat;
                pixels_due[pixels_due.size() - LEDS].lit = table_rows[r].k_lit;
            end
            idle_burst();
        end
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_settle();
            load_seed(seeds[ph]);
            calm = (ph == 3);
            if (ph == 1) begin
                send_item(1'b1, CMD_MODE, 8'd2, 8'd0);
                hold_req = 1'b1;
            end
            for (int n = 0; n < 101; n++) begin
                random_item();
                // hold until the engine has emptied, then resume
                if (ph == 2 && n == 50) drain_and_settle();
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
